[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication that is also checked during reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

[rtl/ncov_pkg.sv]
// ---------------------------------------------------------------------------
// ncov_pkg
// Types, field widths and defaults shared by the covariance accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package ncov_pkg;

    // Default sizes of the array, the averaging window and the bin store.
    localparam int MICS_DEF     = 4;
    localparam int FRAMES_DEF   = 16;
    localparam int MAX_BINS_DEF = 512;

    // Fixed field widths of the stream items, the accumulators and the bin count register.
    localparam int MIC_BITS    = 2;
    localparam int BIN_BITS    = 9;
    localparam int FRAME_BITS  = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 37;
    localparam int COV_BITS    = 33;
    localparam int CFG_BITS    = 10;

    // Reset value of the bin count register.
    localparam logic [CFG_BITS-1:0] BIN_COUNT_RST = 10'd512;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_USED  = MIC_BITS + BIN_BITS + FRAME_BITS + 2 * SAMPLE_BITS;
    localparam int IN_BITS  = ((IN_USED + 7) / 8) * 8;
    localparam int OUT_USED = 2 * MIC_BITS + BIN_BITS + 2 * COV_BITS;
    localparam int OUT_BITS = ((OUT_USED + 7) / 8) * 8;

    // Quotient bits resolved by the divider in one cycle.
    localparam int DIV_STEP = 8;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_EM_ISSUE,
        ST_EM_WAIT
    } t_state;

    // Divider control from the sequencer.
    typedef struct packed {
        logic start;
        logic take;
    } t_div_ctl;

endpackage

`default_nettype wire

[rtl/ncov_ram.sv]
// ---------------------------------------------------------------------------
// ncov_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module ncov_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/ncov_div.sv]
// ---------------------------------------------------------------------------
// ncov_div
// Signed division of an accumulator by the frame count, truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module ncov_div #(
    parameter int FRAMES = ncov_pkg::FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ncov_pkg::t_div_ctl                  i_ctl,
    input  logic signed [ncov_pkg::ACC_BITS-1:0] i_dividend,
    output logic                                o_done,
    output logic signed [ncov_pkg::COV_BITS-1:0] o_quot
);
    import ncov_pkg::*;

    localparam int REM_W = $clog2(FRAMES + 1);
    localparam int STEPS = (ACC_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int MAG_W = STEPS * DIV_STEP;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(FRAMES);

    logic                r_busy;
    logic                r_done;
    logic                r_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [MAG_W-1:0]    r_quot;
    logic [REM_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [ACC_BITS-1:0] dividend_u;
    logic [ACC_BITS-1:0] mag_start;
    logic [REM_W-1:0]    rem_v;
    logic [MAG_W-1:0]    quot_v;
    logic [COV_BITS-1:0] quot_low;

    // Magnitude of the dividend; the most negative value maps to its unsigned size.
    assign dividend_u = i_dividend;
    assign mag_start  = dividend_u[ACC_BITS-1] ? (~dividend_u + 1'b1) : dividend_u;

    // One group of restoring long-division steps, most significant bit first.
    always_comb begin : div_steps
        logic [REM_W:0] trial;
        rem_v  = r_rem;
        quot_v = r_quot;
        trial  = '0;
        for (int b = 0; b < DIV_STEP; b++) begin
            trial = {rem_v, r_mag[MAG_W-1-b]};
            if (trial >= DIVISOR) begin
                trial  = trial - DIVISOR;
                quot_v = {quot_v[MAG_W-2:0], 1'b1};
            end else begin
                quot_v = {quot_v[MAG_W-2:0], 1'b0};
            end
            rem_v = trial[REM_W-1:0];
        end
    end

    // Control: busy while steps remain, done until the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_ctl.take) begin
            r_done <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_neg  <= dividend_u[ACC_BITS-1];
            r_mag  <= MAG_W'(mag_start);
            r_quot <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_mag  <= r_mag << DIV_STEP;
            r_quot <= quot_v;
            r_rem  <= rem_v;
        end
    end

    // Restore the sign and keep the low result bits.
    assign quot_low = r_quot[COV_BITS-1:0];
    assign o_quot   = r_neg ? (~quot_low + 1'b1) : quot_low;
    assign o_done   = r_done;

endmodule

`default_nettype wire

[rtl/noise_covariance_accumulator.sv]
// Flow: a sample that is not from the last mic is stored in the sample buffers; the
// last-mic sample of a bin starts MICS*MICS pair updates, one accumulator RAM update per cycle.
// Emission: each entry passes through the RAM read-modify-write and the five-step divider,
// and no sample is taken until the last entry of the bin is loaded into the output register.
// Samples are accepted only while the sequencer is idle.
// Reset: a clearing sweep writes zero into all 2**(log2 MAX_BINS + 2*log2 MICS) accumulator
// entries (8192 by default) while s_axis_tready stays low.
// ---------------------------------------------------------------------------
// noise_covariance_accumulator
// Per-bin spatial noise covariance of a microphone array, averaged over frames.
// ---------------------------------------------------------------------------
`default_nettype none

module noise_covariance_accumulator #(
    parameter int MICS     = ncov_pkg::MICS_DEF,
    parameter int FRAMES   = ncov_pkg::FRAMES_DEF,
    parameter int MAX_BINS = ncov_pkg::MAX_BINS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Bin count register write.
    input  logic                          i_cfg_we,
    input  logic [ncov_pkg::CFG_BITS-1:0] i_cfg_wdata,
    // Sample stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: mic_index, bin_index, frame_index, sample_real, sample_imag.
    input  logic [ncov_pkg::IN_BITS-1:0]  s_axis_tdata,
    // Covariance stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: row_mic, col_mic, out_bin, cov_real, cov_imag.
    output logic [ncov_pkg::OUT_BITS-1:0] m_axis_tdata,
    // last_of_bin.
    output logic                          m_axis_tlast
);
    import ncov_pkg::*;

    localparam int MIC_W     = $clog2(MICS);
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int ADDR_W    = BIN_W + 2 * MIC_W;
    localparam int ACC_DEPTH = 2 ** ADDR_W;
    localparam int BUF_DEPTH = 2 ** MIC_W;
    localparam int BUF_W     = 2 * SAMPLE_BITS;
    localparam int IN_BIN_LSB   = MIC_BITS;
    localparam int IN_FRAME_LSB = IN_BIN_LSB + BIN_BITS;
    localparam int IN_RE_LSB    = IN_FRAME_LSB + FRAME_BITS;
    localparam int IN_IM_LSB    = IN_RE_LSB + SAMPLE_BITS;

    // Input fields.
    logic [MIC_BITS-1:0]   in_mic;
    logic [BIN_BITS-1:0]   in_bin;
    logic [FRAME_BITS-1:0] in_frame;
    logic [BUF_W-1:0]      in_sample;

    assign in_mic    = s_axis_tdata[MIC_BITS-1:0];
    assign in_bin    = s_axis_tdata[IN_BIN_LSB +: BIN_BITS];
    assign in_frame  = s_axis_tdata[IN_FRAME_LSB +: FRAME_BITS];
    assign in_sample = {s_axis_tdata[IN_IM_LSB +: SAMPLE_BITS],
                        s_axis_tdata[IN_RE_LSB +: SAMPLE_BITS]};

    // Sequencer and control registers.
    t_state              r_state;
    t_state              n_state;
    logic [CFG_BITS-1:0] r_bin_count;
    logic [BIN_W-1:0]    r_bin;
    logic [MIC_W-1:0]    r_ki;
    logic [MIC_W-1:0]    r_kj;
    logic [ADDR_W-1:0]   r_clr_addr;

    // Read-modify-write pipeline.
    logic                       r_v1;
    logic                       r_e1;
    logic [ADDR_W-1:0]          r_a1;
    logic                       r_v2;
    logic                       r_e2;
    logic [ADDR_W-1:0]          r_a2;
    logic signed [2*SAMPLE_BITS-1:0] r_prr;
    logic signed [2*SAMPLE_BITS-1:0] r_pii;
    logic signed [2*SAMPLE_BITS-1:0] r_pir;
    logic signed [2*SAMPLE_BITS-1:0] r_pri;
    logic signed [ACC_BITS-1:0] r_acc_re;
    logic signed [ACC_BITS-1:0] r_acc_im;

    // Output register.
    logic                r_o_valid;
    logic [OUT_BITS-1:0] r_o_data;
    logic                r_o_last;

    logic                in_xfer;
    logic                item_ok;
    logic                is_last_mic;
    logic                is_emit;
    logic                k_last;
    logic                kj_end;
    logic                clr_end;
    logic                issue;
    logic                clearing;
    logic                load_out;
    logic                div_done;
    logic [ADDR_W-1:0]   rd_addr;
    logic [BUF_W-1:0]    buf_a_q;
    logic [BUF_W-1:0]    buf_b_q;
    logic [ACC_BITS-1:0] acc_re_q;
    logic [ACC_BITS-1:0] acc_im_q;
    logic signed [SAMPLE_BITS-1:0] a_re;
    logic signed [SAMPLE_BITS-1:0] a_im;
    logic signed [SAMPLE_BITS-1:0] b_re;
    logic signed [SAMPLE_BITS-1:0] b_im;
    logic signed [ACC_BITS-1:0]    sum_re;
    logic signed [ACC_BITS-1:0]    sum_im;
    logic                acc_we;
    logic [ADDR_W-1:0]   acc_waddr;
    logic [ACC_BITS-1:0] acc_wdata_re;
    logic [ACC_BITS-1:0] acc_wdata_im;
    logic                done_re;
    logic                done_im;
    logic signed [COV_BITS-1:0] q_re;
    logic signed [COV_BITS-1:0] q_im;
    t_div_ctl            div_ctl;

    // Item decode: range checks, last mic of a bin, closing frame.
    assign in_xfer     = s_axis_tvalid & s_axis_tready;
    assign item_ok     = (32'(in_mic) < MICS) && (CFG_BITS'(in_bin) < r_bin_count)
                         && (32'(in_bin) < MAX_BINS);
    assign is_last_mic = (MIC_W'(in_mic) == MIC_W'(MICS - 1));
    assign is_emit     = (32'(in_frame) == 32'(FRAMES - 1));

    // Pair counter and clearing sweep end conditions.
    assign kj_end  = (r_kj == MIC_W'(MICS - 1));
    assign k_last  = kj_end && (r_ki == MIC_W'(MICS - 1));
    assign clr_end = (r_clr_addr == '1);
    assign div_done = done_re & done_im;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_end) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_xfer && item_ok && is_last_mic) begin
                    n_state = is_emit ? ST_EM_ISSUE : ST_ACC;
                end
            end
            ST_ACC: begin
                if (k_last) n_state = ST_IDLE;
            end
            ST_EM_ISSUE: begin
                n_state = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                if (div_done && (!r_o_valid || m_axis_tready)) begin
                    n_state = k_last ? ST_IDLE : ST_EM_ISSUE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        clearing      = 1'b0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_CLEAR:    clearing = 1'b1;
            ST_IDLE:     s_axis_tready = 1'b1;
            ST_ACC:      issue = 1'b1;
            ST_EM_ISSUE: issue = 1'b1;
            ST_EM_WAIT:  load_out = div_done && (!r_o_valid || m_axis_tready);
            default:     s_axis_tready = 1'b0;
        endcase
    end

    // State, configuration and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_bin_count <= BIN_COUNT_RST;
            r_clr_addr  <= '0;
            r_ki        <= '0;
            r_kj        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bin_count <= i_cfg_wdata;
            end
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (in_xfer) begin
                r_ki <= '0;
                r_kj <= '0;
            end else if ((r_state == ST_ACC) || load_out) begin
                r_kj <= kj_end ? '0 : r_kj + 1'b1;
                r_ki <= kj_end ? r_ki + 1'b1 : r_ki;
            end
        end
    end

    // Bin of the pass in progress.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_bin <= BIN_W'(in_bin);
        end
    end

    // Sample buffers: two copies so that both mics of a pair are read in the same cycle.
    ncov_ram #(.WIDTH(BUF_W), .DEPTH(BUF_DEPTH)) u_buf_a (
        .i_clk   (i_clk),
        .i_we    (in_xfer && item_ok),
        .i_waddr (MIC_W'(in_mic)),
        .i_wdata (in_sample),
        .i_raddr (r_ki),
        .o_rdata (buf_a_q)
    );

    ncov_ram #(.WIDTH(BUF_W), .DEPTH(BUF_DEPTH)) u_buf_b (
        .i_clk   (i_clk),
        .i_we    (in_xfer && item_ok),
        .i_waddr (MIC_W'(in_mic)),
        .i_wdata (in_sample),
        .i_raddr (r_kj),
        .o_rdata (buf_b_q)
    );

    // Accumulator stores, addressed by bin, row mic and column mic.
    assign rd_addr      = {r_bin, r_ki, r_kj};
    assign acc_we       = clearing | r_v2;
    assign acc_waddr    = clearing ? r_clr_addr : r_a2;
    assign acc_wdata_re = (clearing || r_e2) ? '0 : sum_re;
    assign acc_wdata_im = (clearing || r_e2) ? '0 : sum_im;

    ncov_ram #(.WIDTH(ACC_BITS), .DEPTH(ACC_DEPTH)) u_acc_re (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata_re),
        .i_raddr (rd_addr),
        .o_rdata (acc_re_q)
    );

    ncov_ram #(.WIDTH(ACC_BITS), .DEPTH(ACC_DEPTH)) u_acc_im (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata_im),
        .i_raddr (rd_addr),
        .o_rdata (acc_im_q)
    );

    // Pipeline valid, mode and address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1 <= (r_state == ST_EM_ISSUE);
        r_a1 <= rd_addr;
        r_e2 <= r_e1;
        r_a2 <= r_a1;
    end

    // First stage after the read: the four partial products of x_i * conj(x_j).
    assign a_re = $signed(buf_a_q[SAMPLE_BITS-1:0]);
    assign a_im = $signed(buf_a_q[BUF_W-1:SAMPLE_BITS]);
    assign b_re = $signed(buf_b_q[SAMPLE_BITS-1:0]);
    assign b_im = $signed(buf_b_q[BUF_W-1:SAMPLE_BITS]);

    always_ff @(posedge i_clk) begin
        r_prr    <= a_re * b_re;
        r_pii    <= a_im * b_im;
        r_pir    <= a_im * b_re;
        r_pri    <= a_re * b_im;
        r_acc_re <= $signed(acc_re_q);
        r_acc_im <= $signed(acc_im_q);
    end

    // Second stage: accumulate with wrap; written back, or zeroed on emission.
    assign sum_re = r_acc_re + ACC_BITS'(r_prr) + ACC_BITS'(r_pii);
    assign sum_im = r_acc_im + ACC_BITS'(r_pir) - ACC_BITS'(r_pri);

    // Averaging by the frame count.
    assign div_ctl.start = r_v2 & r_e2;
    assign div_ctl.take  = load_out;

    ncov_div #(.FRAMES(FRAMES)) u_div_re (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (sum_re),
        .o_done     (done_re),
        .o_quot     (q_re)
    );

    ncov_div #(.FRAMES(FRAMES)) u_div_im (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (sum_im),
        .o_done     (done_im),
        .o_quot     (q_im)
    );

    // Output register: holds one entry until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_data <= {{(OUT_BITS - OUT_USED){1'b0}}, q_im, q_re, BIN_BITS'(r_bin),
                         MIC_BITS'(r_kj), MIC_BITS'(r_ki)};
            r_o_last <= k_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire

[rtl/ncov_chk.sv]
// ---------------------------------------------------------------------------
// ncov_chk
// Port-level checks of the covariance accumulator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ncov_chk #(
    parameter int MICS = ncov_pkg::MICS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    // Fields from bit 0: row_mic, col_mic, out_bin, cov_real, cov_imag.
    input logic [ncov_pkg::OUT_BITS-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import ncov_pkg::*;

    logic [MIC_BITS-1:0] row_mic;
    logic [MIC_BITS-1:0] col_mic;
    logic                o_stall;
    logic                o_last_entry;

    assign row_mic      = m_axis_tdata[MIC_BITS-1:0];
    assign col_mic      = m_axis_tdata[MIC_BITS +: MIC_BITS];
    assign o_stall      = m_axis_tvalid && !m_axis_tready;
    assign o_last_entry = (row_mic == MIC_BITS'(MICS - 1)) && (col_mic == MIC_BITS'(MICS - 1));

    // A stalled result transfer keeps its payload.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // The clearing sweep after reset takes no samples.
    `ASSERT_NEXT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n, !s_axis_tready)

    // While a bin is still being emitted, no new sample is taken.
    `ASSERT_IMPL(a_no_input_mid_bin, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // The last entry of a bin is the bottom-right corner of the matrix.
    `ASSERT_IMPL(a_last_is_corner, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, o_last_entry)

endmodule

bind noise_covariance_accumulator ncov_chk #(.MICS(MICS)) u_ncov_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[sim/tb_noise_covariance_accumulator.sv]
// ---------------------------------------------------------------------------
// tb_noise_covariance_accumulator
// Self-checking bench for the noise covariance accumulator. A queue of
// samples feeds a stream driver with random gaps, and an in-bench model of
// the per-bin accumulators predicts every averaged covariance entry. A
// monitor with random back-pressure compares each entry field by field.
// The run steps through several bin counts, the extremes among them.
// ---------------------------------------------------------------------------

module tb_noise_covariance_accumulator;

    timeunit 1ns;
    timeprecision 1ps;

    import ncov_pkg::*;

    localparam int N_MIC       = MICS_DEF;
    localparam int N_FRAME     = FRAMES_DEF;
    localparam int N_BIN       = MAX_BINS_DEF;
    localparam int N_ENTRY     = N_BIN * N_MIC * N_MIC;
    localparam int SETTLE      = 2 * (1 + N_MIC * N_MIC) + 6;
    localparam int CYCLE_LIMIT = 400000;

    // Bit positions of the covariance stream fields.
    localparam int COL_LSB = MIC_BITS;
    localparam int BIN_LSB = 2 * MIC_BITS;
    localparam int CRE_LSB = BIN_LSB + BIN_BITS;
    localparam int CIM_LSB = CRE_LSB + COV_BITS;

    typedef struct {
        logic [MIC_BITS-1:0]           mic;
        logic [BIN_BITS-1:0]           bin;
        logic [FRAME_BITS-1:0]         frame;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        int                            gap;
    } sample_t;

    typedef struct {
        logic [MIC_BITS-1:0] row;
        logic [MIC_BITS-1:0] col;
        logic [BIN_BITS-1:0] bin;
        logic [COV_BITS-1:0] re;
        logic [COV_BITS-1:0] im;
        logic                tail;
    } cov_entry_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // Fields from bit 0: mic_index, bin_index, frame_index, sample_real, sample_imag.
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // Fields from bit 0: row_mic, col_mic, out_bin, cov_real, cov_imag.
    logic [OUT_BITS-1:0] m_axis_tdata;
    // Fields from bit 0: last_of_bin.
    logic                m_axis_tlast;

    // Covariance model state.
    int                            cfg_bins = 512;
    logic signed [SAMPLE_BITS-1:0] mic_re [N_MIC];
    logic signed [SAMPLE_BITS-1:0] mic_im [N_MIC];
    logic signed [ACC_BITS-1:0]    acc_re [N_ENTRY];
    logic signed [ACC_BITS-1:0]    acc_im [N_ENTRY];

    sample_t    sample_q [$];
    cov_entry_t cov_expect_q [$];

    sample_t drv_item;
    bit      drv_loaded = 1'b0;
    int      drv_gap = 0;
    bit      src_calm = 1'b0;
    int      snk_wait = 0;
    int      snk_max = 7;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      live_count = 0;

    noise_covariance_accumulator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("noise_covariance_accumulator regression: fail");
            $finish;
        end
    end

    function automatic logic [IN_BITS-1:0] pack_sample(input sample_t s);
        logic [IN_BITS-1:0] w;
        w = '0;
        w[IN_USED-1:0] = {s.im, s.re, s.frame, s.bin, s.mic};
        return w;
    endfunction

    // Updates the accumulator model with one accepted sample and queues the
    // averaged entries when the sample closes the averaging window.
    task automatic accumulate_sample(input sample_t s);
        int         i;
        int         j;
        int         k;
        longint     ar;
        longint     ai;
        longint     br;
        longint     bi;
        longint     sum;
        longint     quo;
        cov_entry_t e;
        if (int'(s.bin) >= cfg_bins) return;
        mic_re[s.mic] = s.re;
        mic_im[s.mic] = s.im;
        if (int'(s.mic) != N_MIC - 1) return;
        for (i = 0; i < N_MIC; i++) begin
            for (j = 0; j < N_MIC; j++) begin
                k   = (int'(s.bin) * N_MIC + i) * N_MIC + j;
                ar  = mic_re[i];
                ai  = mic_im[i];
                br  = mic_re[j];
                bi  = mic_im[j];
                sum = longint'(acc_re[k]) + ar * br + ai * bi;
                acc_re[k] = sum[ACC_BITS-1:0];
                sum = longint'(acc_im[k]) + ai * br - ar * bi;
                acc_im[k] = sum[ACC_BITS-1:0];
            end
        end
        if (int'(s.frame) != N_FRAME - 1) return;
        // Averaging divides with truncation toward zero, then clears the bin.
        for (i = 0; i < N_MIC; i++) begin
            for (j = 0; j < N_MIC; j++) begin
                k      = (int'(s.bin) * N_MIC + i) * N_MIC + j;
                e.row  = i;
                e.col  = j;
                e.bin  = s.bin;
                quo    = longint'(acc_re[k]) / N_FRAME;
                e.re   = quo[COV_BITS-1:0];
                quo    = longint'(acc_im[k]) / N_FRAME;
                e.im   = quo[COV_BITS-1:0];
                e.tail = (i == N_MIC - 1) && (j == N_MIC - 1);
                cov_expect_q.push_back(e);
                acc_re[k] = '0;
                acc_im[k] = '0;
            end
        end
    endtask

    // Compares one covariance transfer with the oldest expected entry.
    task automatic check_entry();
        cov_entry_t got;
        cov_entry_t want;
        got.row  = m_axis_tdata[0 +: MIC_BITS];
        got.col  = m_axis_tdata[COL_LSB +: MIC_BITS];
        got.bin  = m_axis_tdata[BIN_LSB +: BIN_BITS];
        got.re   = m_axis_tdata[CRE_LSB +: COV_BITS];
        got.im   = m_axis_tdata[CIM_LSB +: COV_BITS];
        got.tail = m_axis_tlast;
        if (cov_expect_q.size() == 0) begin
            $error("unexpected covariance transfer: bin %0d row %0d col %0d",
                   got.bin, got.row, got.col);
            mismatch_count++;
            return;
        end
        want = cov_expect_q.pop_front();
        if (got.row !== want.row) begin
            $error("row_mic mismatch: expected %0d, got %0d", want.row, got.row);
            mismatch_count++;
        end
        if (got.col !== want.col) begin
            $error("col_mic mismatch: expected %0d, got %0d", want.col, got.col);
            mismatch_count++;
        end
        if (got.bin !== want.bin) begin
            $error("out_bin mismatch: expected %0d, got %0d", want.bin, got.bin);
            mismatch_count++;
        end
        if (got.re !== want.re) begin
            $error("cov_real mismatch: expected %0d, got %0d",
                   $signed(want.re), $signed(got.re));
            mismatch_count++;
        end
        if (got.im !== want.im) begin
            $error("cov_imag mismatch: expected %0d, got %0d",
                   $signed(want.im), $signed(got.im));
            mismatch_count++;
        end
        if (got.tail !== want.tail) begin
            $error("last_of_bin mismatch: expected %0d, got %0d", want.tail, got.tail);
            mismatch_count++;
        end
    endtask

    // Sample driver: each queued sample goes out after its own idle gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                accumulate_sample(drv_item);
                drv_loaded = 1'b0;
            end
            if (!drv_loaded && sample_q.size() > 0) begin
                drv_item   = sample_q.pop_front();
                drv_loaded = 1'b1;
                drv_gap    = drv_item.gap;
            end
            if (drv_loaded && drv_gap == 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pack_sample(drv_item);
            end else begin
                s_axis_tvalid <= 1'b0;
                if (drv_loaded) drv_gap--;
            end
        end
    end

    // Covariance monitor with a random, possibly empty, stall after each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_entry();
                snk_wait = $urandom_range(0, snk_max);
                if ($urandom_range(0, 31) == 0) snk_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_sample(input int mic, input int bin, input int frame,
                               input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im);
        sample_t s;
        s.mic   = mic;
        s.bin   = bin;
        s.frame = frame;
        s.re    = re;
        s.im    = im;
        s.gap   = src_calm ? 0 : $urandom_range(0, 7);
        if (bin < cfg_bins) live_count++;
        sample_q.push_back(s);
    endtask

    function automatic int pick_bin();
        int top;
        top = (cfg_bins > N_BIN) ? N_BIN : cfg_bins;
        if (cfg_bins == 0) return $urandom_range(0, N_BIN - 1);
        if (top < N_BIN && $urandom_range(0, 9) == 0) return $urandom_range(top, N_BIN - 1);
        return $urandom_range(0, top - 1);
    endfunction

    // Random traffic: mostly complete bins over a few frames, the last one
    // closing the window, mixed with stray samples and partial frames.
    task automatic random_traffic(input int target);
        int stop;
        int kind;
        int bin;
        int frames;
        int f;
        int m;
        stop = live_count + target;
        while (live_count < stop) begin
            src_calm = ($urandom_range(0, 3) == 0);
            kind     = $urandom_range(0, 9);
            bin      = pick_bin();
            if (kind < 7) begin
                frames = $urandom_range(1, 4);
                for (f = 0; f < frames; f++) begin
                    for (m = 0; m < N_MIC; m++) begin
                        push_sample(m, bin,
                                    (f == frames - 1) ? N_FRAME - 1 : $urandom_range(0, 14),
                                    draw_sample(), draw_sample());
                    end
                end
            end else if (kind == 7) begin
                push_sample($urandom_range(0, N_MIC - 1), $urandom_range(0, N_BIN - 1),
                            $urandom_range(0, 15), draw_sample(), draw_sample());
            end else begin
                // Partial frame: a random run of mics in random order.
                frames = $urandom_range(1, N_MIC);
                for (m = 0; m < frames; m++) begin
                    push_sample($urandom_range(0, N_MIC - 1), bin, $urandom_range(0, 15),
                                draw_sample(), draw_sample());
                end
            end
        end
    endtask

    // Waits for all samples and entries to clear, then lets the block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        while (sample_q.size() > 0 || drv_loaded || s_axis_tvalid || cov_expect_q.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_bin_count(input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        cfg_bins = value;
    endtask

    initial begin
        int bin;
        int n;
        foreach (acc_re[k]) begin
            acc_re[k] = '0;
            acc_im[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Field extremes on the first bin, closing the window at once.
        push_sample(0, 0, N_FRAME - 1, 16'sh8000, 16'sh8000);
        push_sample(1, 0, N_FRAME - 1, 16'sh7FFF, 16'sh7FFF);
        push_sample(2, 0, N_FRAME - 1, 16'sh8000, 16'sh7FFF);
        push_sample(3, 0, N_FRAME - 1, 16'sh7FFF, 16'sh8000);
        // Two frames on the top bin.
        for (n = 0; n < 2 * N_MIC; n++)
            push_sample(n % N_MIC, N_BIN - 1, (n < N_MIC) ? 3 : N_FRAME - 1,
                        draw_sample(), draw_sample());
        // A last mic alone reuses the held samples of the other mics.
        push_sample(3, 7, N_FRAME - 1, 16'sh0001, 16'shFFFF);
        // Mics out of order and frames out of sequence.
        push_sample(1, 9, 0, 16'sh4000, 16'shC000);
        push_sample(0, 9, 0, 16'shFFFF, 16'sh0000);
        push_sample(3, 9, 8, 16'sh0000, 16'sh7FFF);
        push_sample(3, 9, N_FRAME - 1, 16'shFFFF, 16'sh0000);
        random_traffic(40);
        wait_idle();

        // Single bin in use: everything above bin zero is dropped.
        write_bin_count(1);
        push_sample(3, N_BIN - 1, N_FRAME - 1, draw_sample(), draw_sample());
        random_traffic(25);
        wait_idle();

        // Register maximum, above the bin store size.
        write_bin_count(1023);
        random_traffic(35);
        wait_idle();

        // No bins in use: every sample is dropped.
        write_bin_count(0);
        for (n = 0; n < 12; n++)
            push_sample($urandom_range(0, N_MIC - 1), $urandom_range(0, N_BIN - 1),
                        $urandom_range(0, 15), draw_sample(), draw_sample());
        wait_idle();

        write_bin_count($urandom_range(2, N_BIN - 1));
        random_traffic(40);
        wait_idle();

        // Back to the full store; drive one bin at full scale long enough
        // for the accumulators to wrap before the window closes.
        write_bin_count(N_BIN);
        bin = pick_bin();
        for (n = 0; n < N_MIC - 1; n++) push_sample(n, bin, 0, 16'sh8000, 16'sh8000);
        for (n = 0; n < 33; n++)
            push_sample(N_MIC - 1, bin, (n == 32) ? N_FRAME - 1 : 0, 16'sh8000, 16'sh8000);
        random_traffic(30);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("noise_covariance_accumulator regression: pass");
        end else begin
            $display("noise_covariance_accumulator regression: fail");
        end
        $finish;
    end

endmodule
